// ===== src/srt_pkg.sv =====
`default_nettype none

package srt_pkg;

  localparam int SRT_CAPACITY    = 32;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int TEMP_W          = 21;
  localparam int YEAR_W          = 12;
  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int MIDX_W          = 16;
  localparam int KEY_W           = TEMP_W + MIDX_W + DAY_W;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 48;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_SEARCH   = 3'd1,
    REQ_LIST_ALL = 3'd2,
    REQ_LIST_NEG = 3'd3,
    REQ_CLEAR    = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_SEARCH   = 3'd2,
    ST_LISTED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [YEAR_W-1:0]        year;
    logic [MONTH_W-1:0]       month;
    logic [DAY_W-1:0]         day;
  } rec_t;

  typedef struct packed {
    status_e    status;
    logic       found;
    rec_t       rec;
    logic       last;
  } res_t;

  // Unsigned sort key: biased temperature, month index, day.
  function automatic logic [KEY_W-1:0] srt_key(rec_t r);
    logic [MIDX_W-1:0] midx;
    midx = MIDX_W'(r.year) * MIDX_W'(MONTHS_PER_YEAR) + MIDX_W'(r.month);
    return {~r.temp[TEMP_W-1], r.temp[TEMP_W-2:0], midx, r.day};
  endfunction

endpackage

`default_nettype wire

// ===== src/sorted_record_table.sv =====
`default_nettype none

// Sorted record table. Each request transaction on the slave side is served by a small
// sequencer around one key comparator and a single-port record memory with a registered
// read; the slave side is not ready until the request's final result is handed to the
// output register. A scan step per stored entry reads the memory (registered read), then
// compares. Insert scans to the first stored entry with a larger key, shifts the entries
// from there on up by one, then writes the record; it goes last when no stored key is
// larger. Search scans until a stored temperature matches. Listing hands out each scanned
// entry; a below-zero listing stops at a non-negative entry. Clear and a dropped insert
// on a full table go straight to the result. Request codes outside the defined set are
// consumed without a result.
module sorted_record_table
  import srt_pkg::*;
#(
  parameter int CAPACITY = SRT_CAPACITY
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // day[4:0], month[8:5], year[20:9], temp[41:21], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  wire logic [2:0]            s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // found[0], out_day[5:1], out_month[9:6], out_year[21:10], out_temp[42:22], zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]                 m_axis_tuser_o,
  output logic                       m_axis_tlast_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SH_RD = 7'b0001000,
    S_SH_WR = 7'b0010000,
    S_PUT   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  req_e            op_q, op_d;
  rec_t            new_q, new_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   pos_q, pos_d;
  res_t            res_q, res_d;
  logic            pend_q, pend_d;
  res_t            out_q, out_d;
  logic            out_vld_q, out_vld_d;

  rec_t            mem [CAPACITY];
  rec_t            rd_data_q;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  rec_t            wr_data;
  logic [IW-1:0]   rd_addr;
  logic [CW-1:0]   idx_m1;

  logic            in_fire;
  logic            out_free;
  logic            out_load;
  res_t            res_final;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign idx_m1          = idx_q - CW'(1);
  assign rd_addr         = (state_q == S_SH_RD) ? idx_m1[IW-1:0] : idx_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    res_final = res_q;
    res_final.last = 1'b1;
    if (!pend_q) begin
      res_final = '{status: ST_EMPTY, found: 1'b0, rec: '0, last: 1'b1};
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    new_d    = new_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    res_d    = res_q;
    pend_d   = pend_q;
    wr_en    = 1'b0;
    wr_addr  = idx_q[IW-1:0];
    wr_data  = rd_data_q;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d       = req_e'(s_axis_tuser_i);
          new_d.day   = s_axis_tdata_i[4:0];
          new_d.month = s_axis_tdata_i[8:5];
          new_d.year  = s_axis_tdata_i[20:9];
          new_d.temp  = s_axis_tdata_i[41:21];
          idx_d      = '0;
          pend_d     = 1'b0;
          case (req_e'(s_axis_tuser_i))
            REQ_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                res_d   = '{status: ST_FULL, found: 1'b0, rec: '0, last: 1'b1};
                state_d = S_EMIT;
              end else begin
                state_d = S_FETCH;
              end
            end
            REQ_SEARCH, REQ_LIST_ALL, REQ_LIST_NEG: begin
              state_d = S_FETCH;
            end
            REQ_CLEAR: begin
              cnt_d   = '0;
              res_d   = '{status: ST_EMPTY, found: 1'b0, rec: '0, last: 1'b1};
              state_d = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (idx_q == cnt_q) begin
          case (op_q)
            REQ_INSERT: begin
              pos_d   = cnt_q;
              idx_d   = cnt_q;
              state_d = S_SH_RD;
            end
            REQ_SEARCH: begin
              res_d   = '{status: ST_SEARCH, found: 1'b0, rec: '0, last: 1'b1};
              state_d = S_EMIT;
            end
            default: begin
              res_d   = res_final;
              state_d = S_EMIT;
            end
          endcase
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        case (op_q)
          REQ_INSERT: begin
            if (srt_key(rd_data_q) > srt_key(new_q)) begin
              pos_d   = idx_q;
              idx_d   = cnt_q;
              state_d = S_SH_RD;
            end else begin
              idx_d   = idx_q + CW'(1);
              state_d = S_FETCH;
            end
          end
          REQ_SEARCH: begin
            if (rd_data_q.temp == new_q.temp) begin
              res_d   = '{status: ST_SEARCH, found: 1'b1, rec: '0, last: 1'b1};
              state_d = S_EMIT;
            end else begin
              idx_d   = idx_q + CW'(1);
              state_d = S_FETCH;
            end
          end
          default: begin
            if (op_q == REQ_LIST_NEG && !rd_data_q.temp[TEMP_W-1]) begin
              res_d   = res_final;
              state_d = S_EMIT;
            end else if (!pend_q || out_free) begin
              out_load = pend_q;
              res_d    = '{status: ST_LISTED, found: 1'b0, rec: rd_data_q, last: 1'b0};
              pend_d   = 1'b1;
              idx_d    = idx_q + CW'(1);
              state_d  = S_FETCH;
            end
          end
        endcase
      end
      S_SH_RD: begin
        state_d = (idx_q == pos_q) ? S_PUT : S_SH_WR;
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IW-1:0];
        wr_data = rd_data_q;
        idx_d   = idx_m1;
        state_d = S_SH_RD;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[IW-1:0];
        wr_data = new_q;
        cnt_d   = cnt_q + CW'(1);
        res_d   = '{status: ST_INSERTED, found: 1'b0, rec: '0, last: 1'b1};
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          pend_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_d     = res_q;
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    new_q <= new_d;
    idx_q <= idx_d;
    pos_q <= pos_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {5'b0, out_q.rec.temp, out_q.rec.year, out_q.rec.month,
                            out_q.rec.day, out_q.found};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == '0))
    else $error("entry count moved by more than one");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (s_axis_tuser_i == REQ_INSERT) && (cnt_q == CW'(CAPACITY))
      |=> (state_q == S_EMIT) && (res_q.status == ST_FULL) && (cnt_q == CW'(CAPACITY)))
    else $error("insert on full table not dropped");

  a_pend_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (op_q == REQ_LIST_ALL) || (op_q == REQ_LIST_NEG))
    else $error("pending entry outside a listing");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) || (state_q == S_SCAN) |-> idx_q <= cnt_q)
    else $error("scan index past entry count");

endmodule

`default_nettype wire
